[src/wsd_pkg.sv]
// ----------------------------------------------------------------------------
// wsd_pkg
// Shared types and constants for the WebSocket frame deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package wsd_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam logic [3:0] OP_CLOSE    = 4'h8;
    localparam logic [3:0] OP_PING     = 4'h9;
    localparam logic [7:0] PONG_HEADER = 8'h8A;
    localparam logic [6:0] LEN_EXT     = 7'd126;

    // One classified entry from the parser. A pong pair expands into the
    // pong header byte followed by the length byte held in data.
    typedef struct packed {
        logic       pong_pair;
        logic       dest;
        logic [7:0] data;
        logic [3:0] opcode;
        logic       last;
        logic       empty;
        logic       err;
        logic       closed;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

endpackage

`default_nettype wire

[src/websocket_frame_deframer_unit.sv]
// ----------------------------------------------------------------------------
// websocket_frame_deframer_unit
// Receive-side deframer for unmasked WebSocket frames with pong generation.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake         | payload
//  ---------+-----------+-------------------+-----------------------------------
//  rx       | in        | i_valid / o_stall | i_rx_byte
//  result   | out       | o_valid / i_stall | o_dest, o_out_byte, o_frame_opcode,
//           |           |                   | o_last, o_empty_frame,
//           |           |                   | o_control_error, o_link_closed
//
// One byte per cycle is parsed while the result queue is not full; results pass
// through a queue entry into the output register. A ping header makes two results,
// which leave the output register in turn from a single queue entry.
// o_stall rises only while the 4-entry result queue is full.
// Synchronous active-low reset returns the parser to the first header byte and
// reopens the link; after a close frame every byte is taken and dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module websocket_frame_deframer_unit (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_valid,
    output logic       o_stall,
    input  wire  [7:0] i_rx_byte,
    output logic       o_valid,
    input  wire        i_stall,
    output logic       o_dest,
    output logic [7:0] o_out_byte,
    output logic [3:0] o_frame_opcode,
    output logic       o_last,
    output logic       o_empty_frame,
    output logic       o_control_error,
    output logic       o_link_closed
);
    import wsd_pkg::*;

    t_cmd          push_cmd;
    t_cmd          head_cmd;
    t_queue_status q_status;
    logic          push;
    logic          pop;

    wsd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_rx_byte  (i_rx_byte),
        .i_q_status (q_status),
        .o_stall    (o_stall),
        .o_push     (push),
        .o_cmd      (push_cmd)
    );

    wsd_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_cmd    (push_cmd),
        .i_pop    (pop),
        .o_cmd    (head_cmd),
        .o_status (q_status)
    );

    wsd_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (head_cmd),
        .i_q_status      (q_status),
        .i_stall         (i_stall),
        .o_pop           (pop),
        .o_valid         (o_valid),
        .o_dest          (o_dest),
        .o_out_byte      (o_out_byte),
        .o_frame_opcode  (o_frame_opcode),
        .o_last          (o_last),
        .o_empty_frame   (o_empty_frame),
        .o_control_error (o_control_error),
        .o_link_closed   (o_link_closed)
    );

endmodule

`default_nettype wire

[src/wsd_front.sv]
// ----------------------------------------------------------------------------
// wsd_front
// Header parser: takes one received byte per transfer, tracks the frame
// phase and pushes classified entries into the result queue.
// ----------------------------------------------------------------------------
`default_nettype none

module wsd_front (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_valid,
    input  wire  [7:0]            i_rx_byte,
    input  wsd_pkg::t_queue_status i_q_status,
    output logic                  o_stall,
    output logic                  o_push,
    output wsd_pkg::t_cmd         o_cmd
);
    import wsd_pkg::*;

    typedef enum logic [2:0] {
        PH_HDR0,
        PH_HDR1,
        PH_EXT_HI,
        PH_EXT_LO,
        PH_PAYLOAD,
        PH_SKIP_HI,
        PH_SKIP_LO,
        PH_SKIP
    } t_phase;

    t_phase      r_phase,  n_phase;
    logic [3:0]  r_opcode, n_opcode;
    logic [15:0] r_rem,    n_rem;
    logic [7:0]  r_hi,     n_hi;
    logic        r_closed, n_closed;

    logic        accept;
    logic        body_go;
    logic [15:0] body_len;
    logic [15:0] rem_dec;
    logic [6:0]  len7;
    logic        is_ping;
    logic        is_close;
    t_cmd        cmd;
    logic        push;

    assign o_stall  = i_q_status.full;
    assign accept   = i_valid && !i_q_status.full;
    assign rem_dec  = r_rem - 16'd1;
    assign len7     = i_rx_byte[6:0];
    assign is_ping  = (r_opcode == OP_PING);
    assign is_close = (r_opcode == OP_CLOSE);

    always_comb begin
        n_phase  = r_phase;
        n_opcode = r_opcode;
        n_rem    = r_rem;
        n_hi     = r_hi;
        n_closed = r_closed;
        body_go  = 1'b0;
        body_len = 16'd0;
        push     = 1'b0;
        cmd      = '0;
        cmd.opcode = r_opcode;

        if (accept && !r_closed) begin
            unique case (r_phase)
                PH_HDR0: begin
                    n_opcode = i_rx_byte[3:0];
                    n_phase  = PH_HDR1;
                end
                PH_HDR1: begin
                    if (len7 >= LEN_EXT) begin
                        if (is_ping || is_close) begin
                            push      = 1'b1;
                            cmd.last  = 1'b1;
                            cmd.empty = 1'b1;
                            cmd.err   = 1'b1;
                            n_phase   = PH_SKIP_HI;
                        end else begin
                            n_phase = PH_EXT_HI;
                        end
                    end else if (is_ping) begin
                        push          = 1'b1;
                        cmd.pong_pair = 1'b1;
                        cmd.dest      = 1'b1;
                        cmd.data      = {1'b0, len7};
                        cmd.last      = (len7 == 7'd0);
                        if (len7 == 7'd0) begin
                            n_phase = PH_HDR0;
                        end else begin
                            n_rem   = {9'd0, len7};
                            n_phase = PH_PAYLOAD;
                        end
                    end else begin
                        body_go  = 1'b1;
                        body_len = {9'd0, len7};
                    end
                end
                PH_EXT_HI: begin
                    n_hi    = i_rx_byte;
                    n_phase = PH_EXT_LO;
                end
                PH_EXT_LO: begin
                    body_go  = 1'b1;
                    body_len = {r_hi, i_rx_byte};
                end
                PH_PAYLOAD: begin
                    n_rem       = rem_dec;
                    push        = 1'b1;
                    cmd.dest    = is_ping;
                    cmd.data    = i_rx_byte;
                    cmd.last    = (rem_dec == 16'd0);
                    cmd.closed  = (rem_dec == 16'd0) && is_close;
                    if (rem_dec == 16'd0) begin
                        n_phase = PH_HDR0;
                        if (is_close) begin
                            n_closed = 1'b1;
                        end
                    end
                end
                PH_SKIP_HI: begin
                    n_hi    = i_rx_byte;
                    n_phase = PH_SKIP_LO;
                end
                PH_SKIP_LO: begin
                    n_rem   = {r_hi, i_rx_byte};
                    n_phase = ({r_hi, i_rx_byte} == 16'd0) ? PH_HDR0 : PH_SKIP;
                end
                PH_SKIP: begin
                    n_rem = rem_dec;
                    if (rem_dec == 16'd0) begin
                        n_phase = PH_HDR0;
                    end
                end
                default: begin
                    n_phase = PH_HDR0;
                end
            endcase

            // frame body start, shared by short and extended lengths
            if (body_go) begin
                if (body_len == 16'd0) begin
                    push       = 1'b1;
                    cmd.last   = 1'b1;
                    cmd.empty  = 1'b1;
                    cmd.closed = is_close;
                    n_phase    = PH_HDR0;
                    if (is_close) begin
                        n_closed = 1'b1;
                    end
                end else begin
                    n_rem   = body_len;
                    n_phase = PH_PAYLOAD;
                end
            end
        end
    end

    assign o_push = push;
    assign o_cmd  = cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HDR0;
            r_opcode <= 4'd0;
            r_rem    <= 16'd0;
            r_hi     <= 8'd0;
            r_closed <= 1'b0;
        end else begin
            r_phase  <= n_phase;
            r_opcode <= n_opcode;
            r_rem    <= n_rem;
            r_hi     <= n_hi;
            r_closed <= n_closed;
        end
    end

endmodule

`default_nettype wire

[src/wsd_queue.sv]
// ----------------------------------------------------------------------------
// wsd_queue
// Short FIFO of classified entries between parser and output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module wsd_queue (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_push,
    input  wsd_pkg::t_cmd          i_cmd,
    input  wire                    i_pop,
    output wsd_pkg::t_cmd          o_cmd,
    output wsd_pkg::t_queue_status o_status
);
    import wsd_pkg::*;

    t_cmd                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [QUEUE_AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [QUEUE_AW:0]   r_count,  n_count;
    logic                do_push;
    logic                do_pop;

    assign o_status.full  = (r_count == QUEUE_AW'(0) + (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_status.empty = (r_count == '0);
    assign do_push        = i_push && !o_status.full;
    assign do_pop         = i_pop && !o_status.empty;
    assign o_cmd          = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = r_wr_ptr + QUEUE_AW'(1);
        end
        if (do_pop) begin
            n_rd_ptr = r_rd_ptr + QUEUE_AW'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + (QUEUE_AW+1)'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - (QUEUE_AW+1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (QUEUE_AW+1)'(QUEUE_DEPTH))
        else $error("queue count overflow");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_status.full |-> !i_push)
        else $error("entry pushed into full queue");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_status.empty |-> !i_pop)
        else $error("pop from empty queue");

endmodule

`default_nettype wire

[src/wsd_back.sv]
// ----------------------------------------------------------------------------
// wsd_back
// Output stage: pops queue entries, expands pong pairs into two results and
// holds the current result in an output register until it is transferred.
// ----------------------------------------------------------------------------
`default_nettype none

module wsd_back (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wsd_pkg::t_cmd          i_cmd,
    input  wsd_pkg::t_queue_status i_q_status,
    input  wire                    i_stall,
    output logic                   o_pop,
    output logic                   o_valid,
    output logic                   o_dest,
    output logic [7:0]             o_out_byte,
    output logic [3:0]             o_frame_opcode,
    output logic                   o_last,
    output logic                   o_empty_frame,
    output logic                   o_control_error,
    output logic                   o_link_closed
);
    import wsd_pkg::*;

    logic r_valid, n_valid;
    t_cmd r_out,   n_out;
    logic r_pend_v, n_pend_v;
    t_cmd r_pend,  n_pend;
    logic load;

    assign load = !r_valid || !i_stall;

    always_comb begin
        n_valid  = r_valid;
        n_out    = r_out;
        n_pend_v = r_pend_v;
        n_pend   = r_pend;
        o_pop    = 1'b0;
        if (load) begin
            priority if (r_pend_v) begin
                // second half of a pong pair: the length byte
                n_valid           = 1'b1;
                n_out             = r_pend;
                n_out.pong_pair   = 1'b0;
                n_pend_v          = 1'b0;
            end else if (!i_q_status.empty) begin
                o_pop   = 1'b1;
                n_valid = 1'b1;
                n_out   = i_cmd;
                if (i_cmd.pong_pair) begin
                    n_out.data   = PONG_HEADER;
                    n_out.last   = 1'b0;
                    n_pend_v     = 1'b1;
                    n_pend       = i_cmd;
                end
            end else begin
                n_valid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_pend_v <= 1'b0;
        end else begin
            r_valid  <= n_valid;
            r_pend_v <= n_pend_v;
        end
        r_out  <= n_out;
        r_pend <= n_pend;
    end

    assign o_valid         = r_valid;
    assign o_dest          = r_out.dest;
    assign o_out_byte      = r_out.data;
    assign o_frame_opcode  = r_out.opcode;
    assign o_last          = r_out.last;
    assign o_empty_frame   = r_out.empty;
    assign o_control_error = r_out.err;
    assign o_link_closed   = r_out.closed;

    a_pend_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_v |-> (r_valid && r_out.dest && (r_out.data == PONG_HEADER)))
        else $error("pong length pending without header on output");

    a_no_pop_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_v |-> !o_pop)
        else $error("queue popped while pong length pending");

    a_pair_follow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend_v && !i_stall) |=> (r_valid && r_out.dest && !r_pend_v))
        else $error("pong length did not follow header");

endmodule

`default_nettype wire

[dv/websocket_frame_deframer_unit_test.sv]
// ----------------------------------------------------------------------------
// websocket_frame_deframer_unit_test
// Self-checking bench for the deframer. Frame bytes go in one transfer at a
// time. A bit-accurate parser in the bench predicts every result, and each
// output transfer is compared against the oldest prediction.
// Random input gaps and output stalls are applied, along with a long output
// hold-off. The run ends with a close frame, after which all input is dropped.
// ----------------------------------------------------------------------------
module websocket_frame_deframer_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import wsd_pkg::*;

    localparam logic [3:0] OP_CONT   = 4'h0;
    localparam logic [3:0] OP_TEXT   = 4'h1;
    localparam logic [3:0] OP_BINARY = 4'h2;
    localparam logic [3:0] OP_PONG   = 4'hA;

    typedef enum logic [2:0] {
        ST_HEAD0, ST_HEAD1, ST_XLEN_HI, ST_XLEN_LO,
        ST_BODY, ST_DROP_HI, ST_DROP_LO, ST_DROP
    } t_rx_phase;

    typedef struct {
        logic       dest;
        logic [7:0] data;
        logic [3:0] opcode;
        logic       last;
        logic       empty;
        logic       err;
        logic       closed;
    } t_ws_result;

    logic       i_clk     = 1'b0;
    logic       i_rst_n   = 1'b0;
    logic       i_valid   = 1'b0;
    logic [7:0] i_rx_byte = 8'h00;
    logic       i_stall   = 1'b0;
    logic       o_stall;
    logic       o_valid;
    logic       o_dest;
    logic [7:0] o_out_byte;
    logic [3:0] o_frame_opcode;
    logic       o_last;
    logic       o_empty_frame;
    logic       o_control_error;
    logic       o_link_closed;

    // parser state mirrored by the bench
    t_rx_phase   rx_phase  = ST_HEAD0;
    logic [3:0]  frame_op  = 4'h0;
    logic [15:0] body_left = 16'h0;
    logic [7:0]  xlen_hi   = 8'h0;
    logic        link_down = 1'b0;

    t_ws_result deframed_q[$];
    int  fail_count   = 0;
    int  parsed_items = 0;
    int  hold_off     = 0;
    int  stall_left   = 0;
    bit  no_idle      = 1'b0;

    websocket_frame_deframer_unit u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_rx_byte       (i_rx_byte),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_dest          (o_dest),
        .o_out_byte      (o_out_byte),
        .o_frame_opcode  (o_frame_opcode),
        .o_last          (o_last),
        .o_empty_frame   (o_empty_frame),
        .o_control_error (o_control_error),
        .o_link_closed   (o_link_closed)
    );

    always #1 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------
    task automatic queue_result(input logic dest, input logic [7:0] data, input logic last,
                                input logic empty, input logic err, input logic closed);
        t_ws_result r;
        r.dest   = dest;
        r.data   = data;
        r.opcode = frame_op;
        r.last   = last;
        r.empty  = empty;
        r.err    = err;
        r.closed = closed;
        deframed_q.push_back(r);
    endtask

    task automatic open_body(input logic [15:0] len);
        logic closing;
        closing = (frame_op == OP_CLOSE);
        if (len == 16'd0) begin
            queue_result(1'b0, 8'h00, 1'b1, 1'b1, 1'b0, closing);
            if (closing) link_down = 1'b1;
            rx_phase = ST_HEAD0;
        end else begin
            body_left = len;
            rx_phase  = ST_BODY;
        end
    endtask

    task automatic deframe_byte(input logic [7:0] b);
        logic [6:0] len7;
        logic       is_ctrl;
        logic       fin;
        if (link_down) return;
        case (rx_phase)
            ST_HEAD0: begin
                frame_op = b[3:0];
                rx_phase = ST_HEAD1;
            end
            ST_HEAD1: begin
                len7    = b[6:0];
                is_ctrl = (frame_op == OP_PING) || (frame_op == OP_CLOSE);
                if (len7 >= LEN_EXT) begin
                    if (is_ctrl) begin
                        queue_result(1'b0, 8'h00, 1'b1, 1'b1, 1'b1, 1'b0);
                        rx_phase = ST_DROP_HI;
                    end else begin
                        rx_phase = ST_XLEN_HI;
                    end
                end else if (frame_op == OP_PING) begin
                    queue_result(1'b1, PONG_HEADER, 1'b0, 1'b0, 1'b0, 1'b0);
                    queue_result(1'b1, {1'b0, len7}, len7 == 7'd0, 1'b0, 1'b0, 1'b0);
                    if (len7 == 7'd0) begin
                        rx_phase = ST_HEAD0;
                    end else begin
                        body_left = {9'd0, len7};
                        rx_phase  = ST_BODY;
                    end
                end else begin
                    open_body({9'd0, len7});
                end
            end
            ST_XLEN_HI: begin
                xlen_hi  = b;
                rx_phase = ST_XLEN_LO;
            end
            ST_XLEN_LO: open_body({xlen_hi, b});
            ST_BODY: begin
                body_left = body_left - 16'd1;
                fin       = (body_left == 16'd0);
                queue_result(frame_op == OP_PING, b, fin, 1'b0, 1'b0,
                             fin && (frame_op == OP_CLOSE));
                if (fin) begin
                    if (frame_op == OP_CLOSE) link_down = 1'b1;
                    rx_phase = ST_HEAD0;
                end
            end
            ST_DROP_HI: begin
                xlen_hi  = b;
                rx_phase = ST_DROP_LO;
            end
            ST_DROP_LO: begin
                body_left = {xlen_hi, b};
                rx_phase  = (body_left == 16'd0) ? ST_HEAD0 : ST_DROP;
            end
            default: begin
                body_left = body_left - 16'd1;
                if (body_left == 16'd0) rx_phase = ST_HEAD0;
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Output side: random stalls, long hold-off, result check
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (hold_off > 0) begin
            hold_off = hold_off - 1;
            i_stall <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left = stall_left - 1;
            i_stall <= 1'b1;
        end else if (!no_idle && $urandom_range(0, 99) < 25) begin
            stall_left = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40)
                                                        : $urandom_range(0, 2);
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin : check_results
        t_ws_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (deframed_q.size() == 0) begin
                $error("result transfer with nothing predicted: byte %0h", o_out_byte);
                fail_count++;
            end else begin
                want = deframed_q.pop_front();
                check_field("dest", 8'(want.dest), 8'(o_dest));
                check_field("out_byte", want.data, o_out_byte);
                check_field("frame_opcode", 8'(want.opcode), 8'(o_frame_opcode));
                check_field("last", 8'(want.last), 8'(o_last));
                check_field("empty_frame", 8'(want.empty), 8'(o_empty_frame));
                check_field("control_error", 8'(want.err), 8'(o_control_error));
                check_field("link_closed", 8'(want.closed), 8'(o_link_closed));
            end
        end
    end

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------
    function automatic int rx_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(15, 40);
    endfunction

    // Leaves i_valid high after the transfer; a following call keeps it high
    // unless it draws a gap, and wait_for_results lowers it.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = rx_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_rx_byte <= b;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        parsed_items++;
        deframe_byte(b);
    endtask

    task automatic wait_for_results();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (deframed_q.size() != 0) @(posedge i_clk);
    endtask

    // Random byte that can never close the link: a close header is pushed to
    // extended length, and extended lengths are kept short.
    function automatic logic [7:0] noise_byte();
        logic [7:0] b;
        b = 8'($urandom);
        case (rx_phase)
            ST_HEAD1:               if (frame_op == OP_CLOSE) b[6:1] = 6'h3F;
            ST_XLEN_HI, ST_DROP_HI: b = {7'd0, b[0]};
            default: ;
        endcase
        return b;
    endfunction

    task automatic resync_stream();
        while (rx_phase != ST_HEAD0) send_byte(noise_byte());
    endtask

    task automatic send_frame(input logic [3:0] op, input int len, input bit xlen,
                              input int cut);
        logic [7:0] b;
        b = 8'($urandom);
        b[3:0] = op;
        send_byte(b);
        b = 8'($urandom);
        // length code 126 or 127, mask bit random
        if (xlen) b[6:1] = 6'h3F;
        else b[6:0] = 7'(len);
        send_byte(b);
        if (xlen) begin
            send_byte(8'(len >> 8));
            send_byte(8'(len));
        end
        repeat (cut) send_byte(8'($urandom));
    endtask

    task automatic send_random_frame(input bit broken);
        logic [3:0] op;
        int len;
        int cut;
        int r;
        bit xlen;
        r = $urandom_range(0, 99);
        if (r < 30) op = OP_PING;
        else if (r < 38) op = OP_CLOSE;
        else op = 4'($urandom_range(0, 15));
        r = $urandom_range(0, 99);
        xlen = (r >= 90) || (op == OP_CLOSE);
        if (xlen) len = ($urandom_range(0, 4) == 0) ? $urandom_range(126, 600)
                                                     : $urandom_range(0, 40);
        else if (r < 15) len = 0;
        else if (r < 75) len = $urandom_range(1, 12);
        else len = $urandom_range(13, 125);
        cut = (broken && len > 0) ? $urandom_range(0, len - 1) : len;
        send_frame(op, len, xlen, cut);
        if (broken) resync_stream();
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_directed();
        logic [7:0] seq[$];
        seq = '{
            {4'h8, OP_TEXT}, 8'h02, 8'h00, 8'hFF,
            {4'h8, OP_PONG}, 8'h00,
            {4'h8, OP_PING}, 8'h81, 8'hA5,
            {4'h0, OP_PING}, 8'h00,
            {4'h8, OP_PING}, {1'b0, LEN_EXT}, 8'h00, 8'h02, 8'h11, 8'h22,
            {4'h8, OP_CLOSE}, {1'b1, LEN_EXT + 7'd1}, 8'h00, 8'h00,
            {4'h7, OP_BINARY}, {1'b0, LEN_EXT}, 8'h00, 8'h00,
            {4'hF, OP_CONT}, {1'b0, LEN_EXT + 7'd1}, 8'h00, 8'h01, 8'h5A
        };
        foreach (seq[i]) send_byte(seq[i]);
        wait_for_results();
    endtask

    // Output held off while input keeps coming, so the result queue fills
    // and the block has to stall its input.
    task automatic test_backpressure();
        no_idle  = 1'b1;
        hold_off = 80;
        send_frame(OP_BINARY, 40, 1'b0, 40);
        send_frame(OP_PING, 10, 1'b0, 10);
        no_idle = 1'b0;
        wait_for_results();
    endtask

    task automatic test_random_stream();
        int goal;
        int r;
        goal = parsed_items + 1750;
        while (parsed_items < goal) begin
            r = $urandom_range(0, 99);
            if (r < 6) no_idle = !no_idle;
            if (r < 88) begin
                send_random_frame(1'b0);
            end else if (r < 95) begin
                repeat ($urandom_range(1, 8)) send_byte(noise_byte());
                resync_stream();
            end else if (r < 98) begin
                send_random_frame(1'b1);
            end else begin
                wait_for_results();
            end
        end
        no_idle = 1'b0;
        wait_for_results();
    endtask

    // Must run last: once closed, the link stays closed until reset.
    task automatic test_link_close();
        int len;
        len = $urandom_range(0, 3);
        send_frame(OP_CLOSE, len, 1'b0, len);
        send_byte({4'h8, OP_PING});
        send_byte(8'h00);
        repeat (6) send_byte(8'($urandom));
        wait_for_results();
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_backpressure();
        test_random_stream();
        test_link_close();
        repeat (16) @(posedge i_clk);
        if (fail_count == 0 && deframed_q.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

[files.f]
src/wsd_pkg.sv
src/wsd_front.sv
src/wsd_queue.sv
src/wsd_back.sv
src/websocket_frame_deframer_unit.sv
dv/websocket_frame_deframer_unit_test.sv
